FILE: rtl/dasc_pkg.sv
// Shared types and constants for the display aspect size calculator.
package dasc_pkg;

    localparam int PORT_BITS = 16;
    localparam int OUT_BITS  = 31;

    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // request to the shared divider
    typedef struct packed {
        logic start;
        logic long_op;
    } div_ctl_t;

    // status returned by an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

FILE: rtl/dasc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module dasc_div #(
    parameter int DW = 48,
    parameter int VW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dasc_pkg::div_ctl_t  ctl,
    input  logic [DW-1:0]       dividend,
    input  logic [VW-1:0]       divisor,
    output dasc_pkg::unit_stat_t stat,
    output logic [DW-1:0]       quo,
    output logic [VW-1:0]       rem
);

    localparam int CNT_BITS = $clog2(DW + 1);

    logic [DW-1:0]       q_reg, q_next;
    logic [VW-1:0]       r_reg, r_next;
    logic [VW-1:0]       d_reg, d_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [VW:0] r_sh;
    logic [VW:0] trial;
    logic        ge;

    assign r_sh  = {r_reg, q_reg[DW-1]};
    assign ge    = (r_sh >= {1'b0, d_reg});
    assign trial = r_sh - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            d_next    = divisor;
            r_next    = '0;
            busy_next = 1'b1;
            if (ctl.long_op)
            begin
                q_next   = dividend;
                cnt_next = CNT_BITS'(DW);
            end
            else
            begin
                // short op: only the low VW bits take part
                q_next   = {dividend[VW-1:0], {(DW-VW){1'b0}}};
                cnt_next = CNT_BITS'(VW);
            end
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DW-2:0], ge};
            r_next   = ge ? trial[VW-1:0] : r_sh[VW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;
    assign rem       = r_reg;

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty bit count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a running division");

endmodule

FILE: rtl/dasc_gcd.sv
// Binary greatest common divisor, one subtract or shift step per cycle.
module dasc_gcd #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         a,
    input  logic [W-1:0]         b,
    output dasc_pkg::unit_stat_t stat,
    output logic [W-1:0]         g
);

    localparam int K_BITS = $clog2(W);

    logic [W-1:0]      a_reg, a_next;
    logic [W-1:0]      b_reg, b_next;
    logic [K_BITS-1:0] k_reg, k_next;
    logic              busy_reg, busy_next;
    logic              shift_reg, shift_next;
    logic              done_reg, done_next;

    logic [W:0]   a_minus_b;
    logic [W-1:0] b_minus_a;

    assign a_minus_b = {1'b0, a_reg} - {1'b0, b_reg};
    assign b_minus_a = b_reg - a_reg;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        busy_next  = busy_reg;
        shift_next = shift_reg;
        done_next  = 1'b0;
        if (start)
        begin
            a_next     = a;
            b_next     = b;
            k_next     = '0;
            busy_next  = 1'b1;
            shift_next = 1'b0;
        end
        else if (busy_reg && shift_reg)
        begin
            // restore the common power of two
            a_next = {a_reg[W-2:0], 1'b0};
            k_next = k_reg - 1'b1;
            if (k_reg == K_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (a_reg == b_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    shift_next = 1'b1;
                end
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (!a_minus_b[W])
            begin
                a_next = a_minus_b[W-1:0] >> 1;
            end
            else
            begin
                b_next = b_minus_a >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            shift_reg <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            shift_reg <= shift_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign g         = a_reg;

    a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg && busy_reg |-> k_reg != '0)
        else $error("gcd shifting back with no pending power of two");

endmodule

FILE: rtl/display_aspect_size_calc_core.sv
// Natural display size from frame size and pixel aspect ratio.
// An empty size skips the arithmetic; otherwise the sequence is two multiplies, the gcd,
// three or four short divides, a final multiply and one long divide.
// Throughput: one item at a time; in_ready is high only between items.
// Reset: rst_n clears the sequencer and the output valid asynchronously.
module display_aspect_size_calc_core #(
    parameter int DIM_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          has_video,
    input  logic                          caps_valid,
    input  logic [dasc_pkg::PORT_BITS-1:0] source_width,
    input  logic [dasc_pkg::PORT_BITS-1:0] source_height,
    input  logic [dasc_pkg::PORT_BITS-1:0] par_num,
    input  logic [dasc_pkg::PORT_BITS-1:0] par_den,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dasc_pkg::OUT_BITS-1:0]  out_width,
    output logic [dasc_pkg::OUT_BITS-1:0]  out_height,
    output logic                          size_valid,
    output logic                          saturated
);

    localparam int D  = DIM_BITS;
    localparam int PW = 2 * DIM_BITS;
    localparam int QW = 3 * DIM_BITS;
    localparam int CW = (QW > 32) ? QW : 32;
    localparam int OB = dasc_pkg::OUT_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MULW     = 4'd1;
    localparam logic [3:0] S_MULH     = 4'd2;
    localparam logic [3:0] S_GCD_GO   = 4'd3;
    localparam logic [3:0] S_GCD_WAIT = 4'd4;
    localparam logic [3:0] S_DIV_GO   = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_PROD     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    localparam logic [2:0] OP_DIVW  = 3'd0;
    localparam logic [2:0] OP_DIVH  = 3'd1;
    localparam logic [2:0] OP_MODH  = 3'd2;
    localparam logic [2:0] OP_MODW  = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic          out_valid_reg, out_valid_next;

    logic [D-1:0]  sw_reg, sw_next;
    logic [D-1:0]  sh_reg, sh_next;
    logic [D-1:0]  pn_reg, pn_next;
    logic [D-1:0]  pd_reg, pd_next;
    logic [PW-1:0] dw_reg, dw_next;
    logic [PW-1:0] dh_reg, dh_next;
    logic [PW-1:0] g_reg, g_next;
    logic [QW-1:0] prod_reg, prod_next;
    logic          keep_h_reg, keep_h_next;
    logic [OB-1:0] res_w_reg, res_w_next;
    logic [OB-1:0] res_h_reg, res_h_next;
    logic          res_ok_reg, res_ok_next;
    logic          res_sat_reg, res_sat_next;
    logic [OB-1:0] out_w_reg, out_w_next;
    logic [OB-1:0] out_h_reg, out_h_next;
    logic          out_ok_reg, out_ok_next;
    logic          out_sat_reg, out_sat_next;

    logic [D-1:0]  mul_a;
    logic [PW-1:0] mul_b;
    logic [QW-1:0] mul_p;

    dasc_pkg::div_ctl_t   div_ctl;
    dasc_pkg::unit_stat_t div_stat;
    dasc_pkg::unit_stat_t gcd_stat;
    logic [QW-1:0] div_dividend;
    logic [PW-1:0] div_divisor;
    logic [QW-1:0] div_quo;
    logic [PW-1:0] div_rem;
    logic [PW-1:0] gcd_g;
    logic          quo_sat;
    logic [OB-1:0] quo_clip;
    logic          in_empty;

    assign in_empty = !has_video || !caps_valid
                   || (source_width[D-1:0] == '0) || (source_height[D-1:0] == '0)
                   || (par_num[D-1:0] == '0) || (par_den[D-1:0] == '0);

    // single shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MULW:
            begin
                mul_a = sw_reg;
                mul_b = PW'(pn_reg);
            end
            S_MULH:
            begin
                mul_a = sh_reg;
                mul_b = PW'(pd_reg);
            end
            S_PROD:
            begin
                mul_a = keep_h_reg ? sh_reg : sw_reg;
                mul_b = keep_h_reg ? dw_reg : dh_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        div_ctl.start   = (state_reg == S_DIV_GO);
        div_ctl.long_op = 1'b0;
        case (op_reg)
            OP_DIVW:
            begin
                div_dividend = QW'(dw_reg);
                div_divisor  = g_reg;
            end
            OP_DIVH:
            begin
                div_dividend = QW'(dh_reg);
                div_divisor  = g_reg;
            end
            OP_MODH:
            begin
                div_dividend = QW'(sh_reg);
                div_divisor  = dh_reg;
            end
            OP_MODW:
            begin
                div_dividend = QW'(sw_reg);
                div_divisor  = dw_reg;
            end
            OP_SCALE:
            begin
                div_dividend    = prod_reg;
                div_divisor     = keep_h_reg ? dh_reg : dw_reg;
                div_ctl.long_op = 1'b1;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    dasc_div #(
        .DW(QW),
        .VW(PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    dasc_gcd #(
        .W(PW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_GCD_GO),
        .a     (dw_reg),
        .b     (dh_reg),
        .stat  (gcd_stat),
        .g     (gcd_g)
    );

    assign quo_sat  = (CW'(div_quo) > CW'(dasc_pkg::OUT_MAX));
    assign quo_clip = quo_sat ? dasc_pkg::OUT_MAX : OB'(div_quo);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        pn_next        = pn_reg;
        pd_next        = pd_reg;
        dw_next        = dw_reg;
        dh_next        = dh_reg;
        g_next         = g_reg;
        prod_next      = prod_reg;
        keep_h_next    = keep_h_reg;
        res_w_next     = res_w_reg;
        res_h_next     = res_h_reg;
        res_ok_next    = res_ok_reg;
        res_sat_next   = res_sat_reg;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        out_ok_next    = out_ok_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sw_next = source_width[D-1:0];
                    sh_next = source_height[D-1:0];
                    pn_next = par_num[D-1:0];
                    pd_next = par_den[D-1:0];
                    if (in_empty)
                    begin
                        res_w_next   = '0;
                        res_h_next   = '0;
                        res_ok_next  = 1'b0;
                        res_sat_next = 1'b0;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MULW;
                    end
                end
            end
            S_MULW:
            begin
                dw_next    = mul_p[PW-1:0];
                state_next = S_MULH;
            end
            S_MULH:
            begin
                dh_next    = mul_p[PW-1:0];
                state_next = S_GCD_GO;
            end
            S_GCD_GO:
            begin
                state_next = S_GCD_WAIT;
            end
            S_GCD_WAIT:
            begin
                if (gcd_stat.done)
                begin
                    g_next     = gcd_g;
                    op_next    = OP_DIVW;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    case (op_reg)
                        OP_DIVW:
                        begin
                            dw_next    = div_quo[PW-1:0];
                            op_next    = OP_DIVH;
                            state_next = S_DIV_GO;
                        end
                        OP_DIVH:
                        begin
                            dh_next    = div_quo[PW-1:0];
                            op_next    = OP_MODH;
                            state_next = S_DIV_GO;
                        end
                        OP_MODH:
                        begin
                            if (div_rem == '0)
                            begin
                                keep_h_next = 1'b1;
                                state_next  = S_PROD;
                            end
                            else
                            begin
                                op_next    = OP_MODW;
                                state_next = S_DIV_GO;
                            end
                        end
                        OP_MODW:
                        begin
                            // keep width only when it divides evenly
                            keep_h_next = (div_rem != '0);
                            state_next  = S_PROD;
                        end
                        OP_SCALE:
                        begin
                            res_ok_next  = 1'b1;
                            res_sat_next = quo_sat;
                            if (keep_h_reg)
                            begin
                                res_w_next = quo_clip;
                                res_h_next = OB'(sh_reg);
                            end
                            else
                            begin
                                res_w_next = OB'(sw_reg);
                                res_h_next = quo_clip;
                            end
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PROD:
            begin
                prod_next  = mul_p;
                op_next    = OP_SCALE;
                state_next = S_DIV_GO;
            end
            S_FIN:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    out_w_next     = res_w_reg;
                    out_h_next     = res_h_reg;
                    out_ok_next    = res_ok_reg;
                    out_sat_next   = res_sat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_DIVW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_reg      <= sw_next;
        sh_reg      <= sh_next;
        pn_reg      <= pn_next;
        pd_reg      <= pd_next;
        dw_reg      <= dw_next;
        dh_reg      <= dh_next;
        g_reg       <= g_next;
        prod_reg    <= prod_next;
        keep_h_reg  <= keep_h_next;
        res_w_reg   <= res_w_next;
        res_h_reg   <= res_h_next;
        res_ok_reg  <= res_ok_next;
        res_sat_reg <= res_sat_next;
        out_w_reg   <= out_w_next;
        out_h_reg   <= out_h_next;
        out_ok_reg  <= out_ok_next;
        out_sat_reg <= out_sat_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_width  = out_w_reg;
    assign out_height = out_h_reg;
    assign size_valid = out_ok_reg;
    assign saturated  = out_sat_reg;

    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_w_reg == '0 && out_h_reg == '0 && !out_sat_reg)
        else $error("empty size beat carries a nonzero value");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside the wait state");

    a_gcd_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_stat.done |-> state_reg == S_GCD_WAIT)
        else $error("gcd finished outside the wait state");

endmodule

FILE: tb/dasc_size_checker.sv
// Result checker for the display aspect size calculator: predicts each beat and compares.
module dasc_size_checker #(
    parameter int DIM_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           has_video,
    input  logic                           caps_valid,
    input  logic [dasc_pkg::PORT_BITS-1:0] source_width,
    input  logic [dasc_pkg::PORT_BITS-1:0] source_height,
    input  logic [dasc_pkg::PORT_BITS-1:0] par_num,
    input  logic [dasc_pkg::PORT_BITS-1:0] par_den,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [dasc_pkg::OUT_BITS-1:0]  out_width,
    input  logic [dasc_pkg::OUT_BITS-1:0]  out_height,
    input  logic                           size_valid,
    input  logic                           saturated,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic [dasc_pkg::OUT_BITS-1:0] width;
        logic [dasc_pkg::OUT_BITS-1:0] height;
        logic                          valid;
        logic                          sat;
    } disp_size_t;

    localparam logic [63:0] SIZE_CEIL = 64'(dasc_pkg::OUT_MAX);

    disp_size_t display_size_q[$];
    int         result_beats;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        result_beats = 0;
    end

    function automatic disp_size_t natural_size(
        input logic                           video,
        input logic                           caps,
        input logic [dasc_pkg::PORT_BITS-1:0] w_in,
        input logic [dasc_pkg::PORT_BITS-1:0] h_in,
        input logic [dasc_pkg::PORT_BITS-1:0] num_in,
        input logic [dasc_pkg::PORT_BITS-1:0] den_in
    );
        logic [63:0] mask, sw, sh, pn, pd, dw, dh, a, b, r, w, h;
        disp_size_t  res;
        mask = (64'd1 << DIM_BITS) - 64'd1;
        sw   = 64'(w_in) & mask;
        sh   = 64'(h_in) & mask;
        pn   = 64'(num_in) & mask;
        pd   = 64'(den_in) & mask;
        res  = '0;
        if (!video || !caps || sw == 0 || sh == 0 || pn == 0 || pd == 0)
            return res;
        dw = sw * pn;
        dh = sh * pd;
        a  = dw;
        b  = dh;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        dw = dw / a;
        dh = dh / a;
        // keep height when it is a multiple of the reduced ratio, else try width, else keep height
        if (sh % dh == 0)
        begin
            w = sh * dw / dh;
            h = sh;
        end
        else if (sw % dw == 0)
        begin
            w = sw;
            h = sw * dh / dw;
        end
        else
        begin
            w = sh * dw / dh;
            h = sh;
        end
        res.valid = 1'b1;
        if (w > SIZE_CEIL)
        begin
            w       = SIZE_CEIL;
            res.sat = 1'b1;
        end
        if (h > SIZE_CEIL)
        begin
            h       = SIZE_CEIL;
            res.sat = 1'b1;
        end
        res.width  = w[dasc_pkg::OUT_BITS-1:0];
        res.height = h[dasc_pkg::OUT_BITS-1:0];
        return res;
    endfunction

    task automatic note_mismatch(input bit orphan, input disp_size_t want, input disp_size_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            if (orphan)
                $display("beat %0d: unexpected result w=%0d h=%0d valid=%0b sat=%0b",
                         result_beats, got.width, got.height, got.valid, got.sat);
            else
                $display({"beat %0d: expected w=%0d h=%0d valid=%0b sat=%0b, ",
                          "got w=%0d h=%0d valid=%0b sat=%0b"},
                         result_beats, want.width, want.height, want.valid, want.sat,
                         got.width, got.height, got.valid, got.sat);
        end
    endtask

    always @(posedge clk)
    begin
        disp_size_t want;
        disp_size_t got;
        if (rst_n)
        begin
            // retire the oldest expectation before queuing a new one
            if (out_valid && out_ready)
            begin
                got = {out_width, out_height, size_valid, saturated};
                if (display_size_q.size() == 0)
                    note_mismatch(1'b1, '0, got);
                else
                begin
                    want = display_size_q.pop_front();
                    if (got.width !== want.width || got.height !== want.height ||
                        got.valid !== want.valid || got.sat !== want.sat)
                        note_mismatch(1'b0, want, got);
                end
                result_beats++;
            end
            if (in_valid && in_ready)
                display_size_q.push_back(natural_size(has_video, caps_valid, source_width,
                                                      source_height, par_num, par_den));
            pending = display_size_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives size requests and result backpressure, and gives the verdict.
module tb_top;

    localparam int          DIM          = 16;
    localparam int          RANDOM_ITEMS = 1030;
    localparam int          CALM_ITEMS   = 100;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          LONG_HOLD    = 400;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    typedef struct {
        logic                           video;
        logic                           caps;
        logic [dasc_pkg::PORT_BITS-1:0] w;
        logic [dasc_pkg::PORT_BITS-1:0] h;
        logic [dasc_pkg::PORT_BITS-1:0] num;
        logic [dasc_pkg::PORT_BITS-1:0] den;
    } size_req_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           has_video;
    logic                           caps_valid;
    logic [dasc_pkg::PORT_BITS-1:0] source_width;
    logic [dasc_pkg::PORT_BITS-1:0] source_height;
    logic [dasc_pkg::PORT_BITS-1:0] par_num;
    logic [dasc_pkg::PORT_BITS-1:0] par_den;
    logic                           out_valid;
    logic                           out_ready;
    logic [dasc_pkg::OUT_BITS-1:0]  out_width;
    logic [dasc_pkg::OUT_BITS-1:0]  out_height;
    logic                           size_valid;
    logic                           saturated;
    int                             fail_count;
    int                             pending;
    bit                             calm;
    bit                             hold_req;
    int unsigned                    cycle_count;

    display_aspect_size_calc_core #(.DIM_BITS(DIM)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .has_video(has_video), .caps_valid(caps_valid),
        .source_width(source_width), .source_height(source_height),
        .par_num(par_num), .par_den(par_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_width(out_width), .out_height(out_height),
        .size_valid(size_valid), .saturated(saturated)
    );

    dasc_size_checker #(.DIM_BITS(DIM)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .has_video(has_video), .caps_valid(caps_valid),
        .source_width(source_width), .source_height(source_height),
        .par_num(par_num), .par_den(par_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_width(out_width), .out_height(out_height),
        .size_valid(size_valid), .saturated(saturated),
        .fail_count(fail_count), .pending(pending)
    );

    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    function automatic size_req_t mk_req(input logic v, input logic c, input int w, input int h,
                                         input int n, input int d);
        size_req_t r;
        r.video = v;
        r.caps  = c;
        r.w     = w[dasc_pkg::PORT_BITS-1:0];
        r.h     = h[dasc_pkg::PORT_BITS-1:0];
        r.num   = n[dasc_pkg::PORT_BITS-1:0];
        r.den   = d[dasc_pkg::PORT_BITS-1:0];
        return r;
    endfunction

    function automatic size_req_t rand_req();
        size_req_t r;
        int        pick;
        int        widths[9]  = '{320, 352, 640, 704, 720, 1280, 1440, 1920, 3840};
        int        heights[7] = '{240, 288, 480, 576, 720, 1080, 2160};
        int        pnums[10]  = '{1, 10, 12, 16, 40, 4, 64, 16, 8, 32};
        int        pdens[10]  = '{1, 11, 11, 15, 33, 3, 45, 11, 9, 27};
        pick = $urandom_range(0, 99);
        r = mk_req(1'b1, 1'b1, $urandom_range(1, 65535), $urandom_range(1, 65535),
                   $urandom_range(1, 65535), $urandom_range(1, 65535));
        if (pick < 6)
        begin
            r.video = 1'b0;
            r.caps  = 1'($urandom_range(0, 1));
        end
        else if (pick < 12)
            r.caps = 1'b0;
        else if (pick < 18)
        begin
            case ($urandom_range(0, 3))
                0: r.w   = '0;
                1: r.h   = '0;
                2: r.num = '0;
                default: r.den = '0;
            endcase
        end
        else if (pick < 70 && pick >= 45)
            r = mk_req(1'b1, 1'b1, $urandom_range(1, 64), $urandom_range(1, 64),
                       $urandom_range(1, 64), $urandom_range(1, 64));
        else if (pick >= 70)
        begin
            pick = $urandom_range(0, 9);
            r = mk_req(1'b1, 1'b1, widths[$urandom_range(0, 8)], heights[$urandom_range(0, 6)],
                       pnums[pick], pdens[pick]);
        end
        return r;
    endfunction

    // hold the beat until accepted, then return at the next falling edge
    task automatic offer(input size_req_t r);
        in_valid      <= 1'b1;
        has_video     <= r.video;
        caps_valid    <= r.caps;
        source_width  <= r.w;
        source_height <= r.h;
        par_num       <= r.num;
        par_den       <= r.den;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // result side backpressure
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[display_aspect_size_calc_core] ERROR");
        $finish;
    end

    initial
    begin
        size_req_t directed[$];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        has_video     = 1'b0;
        caps_valid    = 1'b0;
        source_width  = '0;
        source_height = '0;
        par_num       = '0;
        par_den       = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed.push_back(mk_req(1'b0, 1'b1, 1920, 1080, 1, 1));          // no video
        directed.push_back(mk_req(1'b1, 1'b0, 1920, 1080, 1, 1));          // bad caps
        directed.push_back(mk_req(1'b0, 1'b0, 0, 0, 0, 0));
        directed.push_back(mk_req(1'b0, 1'b1, 65535, 65535, 65535, 65535));
        directed.push_back(mk_req(1'b1, 1'b1, 0, 1080, 1, 1));             // zero terms
        directed.push_back(mk_req(1'b1, 1'b1, 1920, 0, 1, 1));
        directed.push_back(mk_req(1'b1, 1'b1, 1920, 1080, 0, 1));
        directed.push_back(mk_req(1'b1, 1'b1, 1920, 1080, 1, 0));
        directed.push_back(mk_req(1'b1, 1'b1, 1, 1, 1, 1));
        directed.push_back(mk_req(1'b1, 1'b1, 65535, 65535, 65535, 65535));
        directed.push_back(mk_req(1'b1, 1'b1, 65535, 1, 65535, 1));        // width clips
        directed.push_back(mk_req(1'b1, 1'b1, 65534, 65535, 1, 65535));    // height clips
        directed.push_back(mk_req(1'b1, 1'b1, 4, 3, 7, 5));                // neither divides
        directed.push_back(mk_req(1'b1, 1'b1, 720, 576, 16, 15));
        directed.push_back(mk_req(1'b1, 1'b1, 720, 480, 8, 9));
        directed.push_back(mk_req(1'b1, 1'b1, 352, 288, 12, 11));
        directed.push_back(mk_req(1'b1, 1'b1, 1, 65535, 1, 65535));
        directed.push_back(mk_req(1'b1, 1'b1, 65535, 65535, 1, 65535));
        directed.push_back(mk_req(1'b1, 1'b1, 65535, 1, 1, 65535));
        foreach (directed[i])
        begin
            offer(directed[i]);
            maybe_gap();
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
                hold_req = 1'b1;
            if (i == 600)
            begin
                // drain completely before going on
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            offer(rand_req());
            maybe_gap();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[display_aspect_size_calc_core] OK");
        else
            $display("[display_aspect_size_calc_core] ERROR");
        $finish;
    end

endmodule
